// File: rtl/core/tlnf_pkg.sv
`default_nettype none

package tlnf_pkg;

  // Input item: one raw byte and the file-start mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // Result item: one output byte and the end-of-run mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOLLAR_EN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SQUEEZE_EN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAB_CARET   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CTRL_CARET  = 3'd4;

  // Numbering modes
  localparam logic [1:0] NUM_OFF      = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONEMPTY = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_I      = 8'h49;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] CARET_SHIFT = 8'd64;

  localparam logic [3:0] DIGIT_NINE  = 4'd9;

endpackage

`default_nettype wire

// File: rtl/core/text_line_number_filter_top.sv
// Channel   Handshake               Payload                    Notes
// in_       in_valid / in_ready     tlnf_pkg::in_item_t        one raw byte per transfer
// out_      out_valid / out_ready   tlnf_pkg::out_item_t       one output byte per transfer
// cfg_      cfg_we                  cfg_addr, cfg_wdata        write only, no wait
//
// Each input transfer loads a run of 1 to NUMBER_DIGITS+3 output bytes into the run
// register; the run then drains one byte per cycle while out_ready is high, so an item
// occupies the block until all its output bytes have transferred (1 for a plain byte,
// up to NUMBER_DIGITS+3 with a line number and a two-byte escape). The next input
// transfer is taken in the cycle the last byte of the run transfers. A squeezed blank
// line is taken but produces nothing. Reset (synchronous, active low) clears
// configuration to zero, the line number to one and the run register to empty.

`default_nettype none

module text_line_number_filter_top #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tlnf_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tlnf_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tlnf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [tlnf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CntW   = 4 * NUMBER_DIGITS;
  localparam int RunLen = NUMBER_DIGITS + 3;
  localparam int IdxW   = $clog2(RunLen);
  // Run layout: digits at 0..NUMBER_DIGITS-1, tab at NUMBER_DIGITS, body after it
  localparam logic [IdxW-1:0] TabIdx  = IdxW'(NUMBER_DIGITS);
  localparam logic [IdxW-1:0] BodyIdx = IdxW'(NUMBER_DIGITS + 1);
  localparam logic [IdxW-1:0] BodyEnd = IdxW'(NUMBER_DIGITS + 2);

  // Configuration registers
  logic [1:0] number_mode_r;
  logic       dollar_en_r;
  logic       squeeze_en_r;
  logic       tab_caret_r;
  logic       ctrl_caret_r;

  // Line state
  logic [CntW-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic            after_nl_r, after_nl_cur;
  logic            sq_r, sq_nxt, sq_cur;

  // Run register: bytes of one item's output, read index and last index
  logic [7:0]      run_r   [RunLen];
  logic [7:0]      run_nxt [RunLen];
  logic            run_valid_r;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [IdxW-1:0] last_idx_r, last_idx_nxt;

  logic [7:0] in_byte;
  logic       is_lf;
  logic       drop;
  logic       num_en;
  logic       in_fire;
  logic       out_fire;
  logic       run_last;

  assign in_byte  = in_data.data_byte;
  assign is_lf    = (in_byte == tlnf_pkg::CHAR_LF);
  assign run_last = (idx_r == last_idx_r);
  assign in_ready = !run_valid_r || (out_ready && run_last);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = run_valid_r && out_ready;

  assign out_valid            = run_valid_r;
  assign out_data.out_byte    = run_r[idx_r];
  assign out_data.last_of_run = run_last;

  // File start restarts the line state before the byte is handled
  assign cnt_cur      = in_data.file_start ? CntW'(1) : cnt_r;
  assign after_nl_cur = in_data.file_start || after_nl_r;
  assign sq_cur       = in_data.file_start ? 1'b0 : sq_r;

  // Drop a blank line that follows an already passed blank line
  assign drop   = squeeze_en_r && is_lf && after_nl_cur && sq_cur;
  assign sq_nxt = squeeze_en_r ? (is_lf && after_nl_cur) : sq_cur;
  assign num_en = after_nl_cur &&
                  ((number_mode_r == tlnf_pkg::NUM_ALL) ||
                   ((number_mode_r == tlnf_pkg::NUM_NONEMPTY) && !is_lf));

  // BCD increment with saturation at all nines
  always_comb begin
    logic [3:0]      d;
    logic            carry;
    logic [CntW-1:0] inc;
    carry = 1'b1;
    inc   = cnt_cur;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = cnt_cur[4*i +: 4];
      if (carry) begin
        inc[4*i +: 4] = (d >= tlnf_pkg::DIGIT_NINE) ? 4'd0 : d + 4'd1;
      end
      carry = carry && (d == tlnf_pkg::DIGIT_NINE);
    end
    // carry out means every digit was nine: hold
    cnt_nxt = (num_en && !carry) ? inc : cnt_cur;
  end

  // Build the run: number prefix, then the body bytes
  always_comb begin
    logic [3:0] d;
    logic       zero_run;
    zero_run = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      d = cnt_cur[4*i +: 4];
      if (d > tlnf_pkg::DIGIT_NINE) begin
        d = tlnf_pkg::DIGIT_NINE;
      end
      zero_run = zero_run && (d == 4'd0);
      run_nxt[NUMBER_DIGITS-1-i] = (zero_run && (i != 0)) ? tlnf_pkg::CHAR_SPACE
                                                           : tlnf_pkg::CHAR_ZERO + {4'd0, d};
    end
    run_nxt[TabIdx] = tlnf_pkg::CHAR_TAB;

    run_nxt[BodyIdx] = in_byte;
    run_nxt[BodyEnd] = in_byte;
    last_idx_nxt     = BodyIdx;
    if (tab_caret_r && (in_byte == tlnf_pkg::CHAR_TAB)) begin
      run_nxt[BodyIdx] = tlnf_pkg::CHAR_CARET;
      run_nxt[BodyEnd] = tlnf_pkg::CHAR_I;
      last_idx_nxt     = BodyEnd;
    end else if (dollar_en_r && is_lf) begin
      run_nxt[BodyIdx] = tlnf_pkg::CHAR_DOLLAR;
      last_idx_nxt     = BodyEnd;
    end else if (ctrl_caret_r && (in_byte < tlnf_pkg::CTRL_LIMIT) &&
                 (in_byte != tlnf_pkg::CHAR_TAB) && !is_lf &&
                 (in_byte != tlnf_pkg::CHAR_CR)) begin
      run_nxt[BodyIdx] = tlnf_pkg::CHAR_CARET;
      run_nxt[BodyEnd] = in_byte + tlnf_pkg::CARET_SHIFT;
      last_idx_nxt     = BodyEnd;
    end else if (ctrl_caret_r && (in_byte == tlnf_pkg::CHAR_DEL)) begin
      run_nxt[BodyIdx] = tlnf_pkg::CHAR_CARET;
      run_nxt[BodyEnd] = tlnf_pkg::CHAR_QMARK;
      last_idx_nxt     = BodyEnd;
    end

    // Skip the prefix when no number goes before this byte
    idx_nxt = num_en ? '0 : BodyIdx;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r <= tlnf_pkg::NUM_OFF;
      dollar_en_r   <= 1'b0;
      squeeze_en_r  <= 1'b0;
      tab_caret_r   <= 1'b0;
      ctrl_caret_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tlnf_pkg::CFG_NUMBER_MODE: number_mode_r <= cfg_wdata;
        tlnf_pkg::CFG_DOLLAR_EN:   dollar_en_r   <= cfg_wdata[0];
        tlnf_pkg::CFG_SQUEEZE_EN:  squeeze_en_r  <= cfg_wdata[0];
        tlnf_pkg::CFG_TAB_CARET:   tab_caret_r   <= cfg_wdata[0];
        tlnf_pkg::CFG_CTRL_CARET:  ctrl_caret_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Line state advances on every input transfer; a dropped line leaves it as is
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= CntW'(1);
      after_nl_r <= 1'b1;
      sq_r       <= 1'b0;
    end else if (in_fire && !drop) begin
      cnt_r      <= cnt_nxt;
      after_nl_r <= is_lf;
      sq_r       <= sq_nxt;
    end
  end

  // Run control: load on a kept input, advance on each output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      idx_r       <= '0;
      last_idx_r  <= '0;
    end else if (in_fire) begin
      run_valid_r <= !drop;
      idx_r       <= idx_nxt;
      last_idx_r  <= last_idx_nxt;
    end else if (out_fire) begin
      if (run_last) begin
        run_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IdxW'(1);
      end
    end
  end

  // Run bytes: payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RunLen; i++) begin
        run_r[i] <= run_nxt[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !run_valid_r |-> in_ready)
    else $error("input not ready with empty run register");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (idx_r <= last_idx_r) && (last_idx_r >= BodyIdx) &&
                    (last_idx_r <= BodyEnd))
    else $error("run index out of range");

  a_kept_item_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !drop) |=> out_valid)
    else $error("kept input produced no output");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !run_last) |=> (out_valid && (idx_r == $past(idx_r) + IdxW'(1))))
    else $error("run stopped before its last byte");

  a_newline_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !drop) |=> (after_nl_r == $past(is_lf)))
    else $error("newline flag not updated");
`endif

endmodule

`default_nettype wire
